>>> src/dq_pkg.sv
// Shared constants, field widths and operation codes of the double-ended queue.
package dq_pkg;

    // Default sizing of the ring store
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the stream fields
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;
    localparam int COUNT_W = 5;

    // Operation codes carried in the slave tuser field
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_AT    = 3'd4
    } t_op;

endpackage

>>> src/dq_ring.sv
// Ring storage of the queue: one write port and one registered read port.
module dq_ring #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Write the addressed slot
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/dq_mod.sv
// Iterative remainder unit: reduces a read position modulo the element count.
module dq_mod #(
    parameter int CW = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [dq_pkg::POS_W-1:0] i_dividend,
    input  logic [CW-1:0]            i_divisor,
    output logic                     o_done,
    output logic [CW-1:0]            o_rem
);

    localparam int BW = $clog2(dq_pkg::POS_W);

    logic                     r_busy;
    logic                     r_done;
    logic [BW-1:0]            r_bit;
    logic [dq_pkg::POS_W-1:0] r_shift;
    logic [CW-1:0]            r_div;
    logic [CW-1:0]            r_rem;
    logic [CW:0]              trial;
    logic [CW:0]              diff;
    logic [CW-1:0]            n_rem;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_shift[dq_pkg::POS_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[CW-1:0];
        end else begin
            n_rem = trial[CW-1:0];
        end
    end

    // Sequence one bit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= BW'(dq_pkg::POS_W - 1);
            end else if (r_busy) begin
                r_bit <= r_bit - 1'b1;
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload of the reduction
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_div   <= i_divisor;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[dq_pkg::POS_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    // Remainder must be below the divisor once finished
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not reduced below divisor");

    // A start always launches the iteration
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("start did not make unit busy");

    // Done and busy never overlap
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done raised while still busy");

endmodule

>>> src/double_ended_queue_top.sv
// Top level of the double-ended queue: stream ports, sequencer and status.
//
// A bounded double-ended queue in a ring of DEPTH slots. Each slave transaction carries
// one operation in tuser (push front, push back, pop front, pop back, read at position)
// and yields exactly one master transaction with the success flag, the value read, the
// front and back values, the count and an empty flag. Items are handled one at a time
// and tready is high only while the sequencer is idle. A push, a pop, a rejected read or
// an unassigned code first updates the ring in the execute state, then the front and
// back slots are fetched through the single registered read port before the result is
// registered for output; the next item can be accepted once the sequencer is idle again.
// For a read at a position on a non-empty store, the position is first reduced modulo
// the count by a remainder unit that retires one of its 16 bits per cycle, and the
// addressed slot is fetched before front and back. A finished result waits in the
// output register until taken; the next item may be accepted meanwhile, and its own
// result is held back until that register is free.
module double_ended_queue_top #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // value[31:0], position[47:32]
    input  logic [2:0]   i_s_tuser,   // operation[2:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata    // ok[0], read_value[32:1], front_value[64:33],
                                      // back_value[96:65], count[101:97],
                                      // empty_res[102], zero pad[103]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOD,
        S_RD_ITEM,
        S_RD_FRONT,
        S_RD_BACK,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [dq_pkg::OP_W-1:0]     r_op;
    logic [dq_pkg::VALUE_W-1:0]  r_value;
    logic [dq_pkg::POS_W-1:0]    r_pos;
    logic [AW-1:0]               r_head;
    logic [CW-1:0]               r_count;
    logic                        r_ok;
    logic                        r_is_read;
    logic [DATA_WIDTH-1:0]       r_rd_val;
    logic [DATA_WIDTH-1:0]       r_front;
    logic                        r_out_valid;
    logic [103:0]                r_out_data;

    logic                        mod_start;
    logic                        mod_done;
    logic [CW-1:0]               mod_rem;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [DATA_WIDTH-1:0]       wdata;
    logic [DATA_WIDTH-1:0]       rdata;
    logic [DATA_WIDTH+31:0]      value_ext;
    logic [AW-1:0]               head_dec;
    logic [AW-1:0]               head_inc;
    logic [CW-1:0]               count_dec;
    logic                        has_room;
    logic                        has_items;
    logic                        out_free;
    logic                        exec_ok;
    logic [31:0]                 rd_out;
    logic [31:0]                 front_out;
    logic [31:0]                 back_out;
    logic [dq_pkg::COUNT_W-1:0]  count_out;

    // Slot index of base plus offset, wrapped once around the ring
    function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        logic [CW:0] wrapped;
        sum     = (CW + 1)'(base) + (CW + 1)'(off);
        wrapped = sum - DEPTH_X;
        if (sum >= DEPTH_X) begin
            ring_at = wrapped[AW-1:0];
        end else begin
            ring_at = sum[AW-1:0];
        end
    endfunction

    // Widen a stored element to the 32-bit field
    function automatic logic [31:0] to_field(input logic [DATA_WIDTH-1:0] d);
        logic [DATA_WIDTH+31:0] ext;
        ext = {32'd0, d};
        to_field = ext[31:0];
    endfunction

    // Neighbouring head positions and status
    assign head_dec  = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
    assign head_inc  = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign count_dec = r_count - 1'b1;
    assign has_room  = (r_count < DEPTH_C);
    assign has_items = (r_count != '0);
    assign out_free  = !r_out_valid || i_m_tready;

    // Success of the operation under execution
    always_comb begin
        case (r_op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: exec_ok = has_room;
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
            dq_pkg::OP_READ_AT:                          exec_ok = has_items;
            default:                                     exec_ok = 1'b0;
        endcase
    end

    // Element to store: low DATA_WIDTH bits of the pushed value
    assign value_ext = {{DATA_WIDTH{1'b0}}, r_value};
    assign wdata     = value_ext[DATA_WIDTH-1:0];

    // Ring write for a push that fits
    always_comb begin
        we    = 1'b0;
        waddr = ring_at(r_head, r_count);
        if (r_state == S_EXEC && has_room) begin
            case (r_op)
                dq_pkg::OP_PUSH_FRONT: begin
                    we    = 1'b1;
                    waddr = head_dec;
                end
                dq_pkg::OP_PUSH_BACK: begin
                    we    = 1'b1;
                end
                default: we = 1'b0;
            endcase
        end
    end

    // Read address follows the fetch sequence
    always_comb begin
        case (r_state)
            S_RD_ITEM:         raddr = ring_at(r_head, mod_rem);
            S_RD_BACK, S_DONE: raddr = ring_at(r_head, count_dec);
            default:           raddr = r_head;
        endcase
    end

    assign mod_start = (r_state == S_EXEC) && (r_op == dq_pkg::OP_READ_AT) && has_items;

    dq_ring #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dq_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_pos),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Result fields, zero where the store is empty
    assign rd_out    = to_field(r_rd_val);
    assign front_out = has_items ? to_field(r_front) : 32'd0;
    assign back_out  = has_items ? to_field(rdata) : 32'd0;
    assign count_out = dq_pkg::COUNT_W'(r_count);

    // Sequencer, queue pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= i_s_tuser;
                        r_value <= i_s_tdata[31:0];
                        r_pos   <= i_s_tdata[47:32];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_ok      <= exec_ok;
                    r_is_read <= mod_start;
                    r_rd_val  <= '0;
                    r_state   <= mod_start ? S_MOD : S_RD_FRONT;
                    case (r_op)
                        dq_pkg::OP_PUSH_FRONT: begin
                            if (has_room) begin
                                r_head  <= head_dec;
                                r_count <= r_count + 1'b1;
                            end
                        end
                        dq_pkg::OP_PUSH_BACK: begin
                            if (has_room) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        dq_pkg::OP_POP_FRONT: begin
                            if (has_items) begin
                                r_head  <= head_inc;
                                r_count <= count_dec;
                            end
                        end
                        dq_pkg::OP_POP_BACK: begin
                            if (has_items) begin
                                r_count <= count_dec;
                            end
                        end
                        default: begin
                            // hold the pointers
                        end
                    endcase
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_state <= S_RD_ITEM;
                    end
                end
                S_RD_ITEM: begin
                    r_state <= S_RD_FRONT;
                end
                S_RD_FRONT: begin
                    if (r_is_read) begin
                        r_rd_val <= rdata;
                    end
                    r_state <= S_RD_BACK;
                end
                S_RD_BACK: begin
                    r_front <= rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, !has_items, count_out, back_out,
                                        front_out, rd_out, r_ok};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Count never exceeds the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("element count beyond depth");

    // An accepted transaction is executed next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

    // Remainder completes only while waiting for it
    a_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_MOD))
        else $error("remainder finished outside its wait state");

endmodule
